FILE: rtl/znszm_pkg.sv
// znszm_pkg: types, codes and constants of the zoned namespace zone manager
// used by zoned_namespace_zone_manager_unit; depends on nothing else
package znszm_pkg;

  // field widths fixed by the command format
  localparam int unsigned FuncW  = 3;
  localparam int unsigned LbaW   = 32;
  localparam int unsigned WpW    = 21;
  localparam int unsigned CntW   = 11;
  localparam int unsigned LogW   = 5;
  localparam int unsigned OffW   = 20;
  localparam int unsigned MaxLog = 20;
  localparam int unsigned DivSteps = 21;
  localparam int unsigned DivCntW  = 5;

  // zone management operations
  typedef enum logic [FuncW-1:0] {
    FN_CLOSE   = 3'd0,
    FN_FINISH  = 3'd1,
    FN_OPEN    = 3'd2,
    FN_RESET   = 3'd3,
    FN_OFFLINE = 3'd4,
    FN_FLUSH   = 3'd5
  } func_e;

  // zone states as kept in the zone table
  typedef enum logic [2:0] {
    ZS_EMPTY   = 3'd0,
    ZS_IOPEN   = 3'd1,
    ZS_EOPEN   = 3'd2,
    ZS_CLOSED  = 3'd3,
    ZS_FULL    = 3'd4,
    ZS_RONLY   = 3'd5,
    ZS_OFFLINE = 3'd6
  } zstate_e;

  // completion status codes
  typedef enum logic [2:0] {
    SC_OK       = 3'd0,
    SC_TRANS    = 3'd1,
    SC_NOACT    = 3'd2,
    SC_NOOPEN   = 3'd3,
    SC_NOAREA   = 3'd4,
    SC_BADOP    = 3'd5,
    SC_BADFIELD = 3'd6
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_ACTIVE = 3'd0,
    REG_MAX_OPEN   = 3'd1,
    REG_MAX_AREA   = 3'd2,
    REG_ZONE_LOG2  = 3'd3,
    REG_ZONE_CAP   = 3'd4,
    REG_AREA_LBAS  = 3'd5,
    REG_FLUSH_GRAN = 3'd6
  } cfg_reg_e;

  // control sequencer
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX,
    S_DIV
  } fsm_e;

  // command request
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [LbaW-1:0]  start_lba;
    logic             area_request;
    logic             all_zones;
  } zm_in_t;

  // completion request
  typedef struct packed {
    logic [2:0]      status;
    logic [2:0]      zone_st;
    logic [WpW-1:0]  write_pointer;
    logic [CntW-1:0] open_count;
    logic [CntW-1:0] active_count;
    logic [CntW-1:0] area_count;
  } zm_out_t;

  // one zone table entry; all zero is an empty zone
  typedef struct packed {
    logic [2:0]     zstate;
    logic [WpW-1:0] wp;
    logic           area_valid;
  } zentry_t;

endpackage

FILE: rtl/znszm_ram.sv
// znszm_ram: generic single write port, single read port ram, registered read
// stands alone; used by zoned_namespace_zone_manager_unit for the zone table
module znszm_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/zoned_namespace_zone_manager_unit.sv
// zoned_namespace_zone_manager_unit: zone state machine of a zoned namespace
// depends on znszm_pkg and znszm_ram (zone table)
//
// Usage
//   Command requests enter on in_valid_i / in_stall_o / in_req_i, one per
//   accept (valid high, stall low). Each command yields exactly one
//   completion request on out_valid_o / out_stall_i / out_req_o.
//   Limits and zone geometry sit in APB registers at byte address 4*i;
//   write them only while no command is in flight. pready is always high.
// Sequence
//   A zone command is a read-modify-write of the zone table: S_RD reads the
//   entry, S_EX evaluates it, writes it back and loads the completion; the
//   next command is taken back in S_IDLE (a zone out of range skips S_RD). A
//   flush past the window check adds 21 remainder steps in S_DIV and a second
//   evaluation. Select-all runs S_RD and S_EX for each zone in turn, plus
//   remainder steps. Only one command is in the sequencer at a time.
// Reset
//   After reset the block clears the zone table, one entry per cycle, with
//   in_stall_o high until every entry is cleared; APB writes are taken meanwhile.
// Back pressure
//   The completion sits in an output register. A new command is taken while
//   it waits; that command holds before its final table write until the register
//   frees up, so no completion is lost or reordered.
module zoned_namespace_zone_manager_unit #(
  parameter int unsigned NUM_ZONES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  znszm_pkg::zm_in_t  in_req_i,
  // completion channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output znszm_pkg::zm_out_t out_req_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import znszm_pkg::*;

  localparam int unsigned ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam logic [ZW-1:0] LastZone = ZW'(NUM_ZONES - 1);
  localparam logic [LbaW-1:0] NumZonesLba = LbaW'(NUM_ZONES);
  localparam int unsigned EW = $bits(zentry_t);

  function automatic logic [CntW-1:0] sat_dec(input logic [CntW-1:0] c);
    sat_dec = (c == '0) ? c : c - CntW'(1);
  endfunction

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [CntW-1:0] max_active_q, max_open_q, max_area_q;
  logic [LogW-1:0] zone_log2_q;
  logic [WpW-1:0]  zone_cap_q, area_lbas_q, flush_gran_q;
  logic            cfg_we;
  cfg_reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= CntW'(1024);
      max_open_q   <= CntW'(1024);
      max_area_q   <= '0;
      zone_log2_q  <= LogW'(16);
      zone_cap_q   <= WpW'(65536);
      area_lbas_q  <= WpW'(256);
      flush_gran_q <= WpW'(16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_ACTIVE: max_active_q <= pwdata[CntW-1:0];
        REG_MAX_OPEN:   max_open_q   <= pwdata[CntW-1:0];
        REG_MAX_AREA:   max_area_q   <= pwdata[CntW-1:0];
        REG_ZONE_LOG2:  zone_log2_q  <= pwdata[LogW-1:0];
        REG_ZONE_CAP:   zone_cap_q   <= pwdata[WpW-1:0];
        REG_AREA_LBAS:  area_lbas_q  <= pwdata[WpW-1:0];
        REG_FLUSH_GRAN: flush_gran_q <= pwdata[WpW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_MAX_ACTIVE: prdata = {21'd0, max_active_q};
      REG_MAX_OPEN:   prdata = {21'd0, max_open_q};
      REG_MAX_AREA:   prdata = {21'd0, max_area_q};
      REG_ZONE_LOG2:  prdata = {27'd0, zone_log2_q};
      REG_ZONE_CAP:   prdata = {11'd0, zone_cap_q};
      REG_AREA_LBAS:  prdata = {11'd0, area_lbas_q};
      REG_FLUSH_GRAN: prdata = {11'd0, flush_gran_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // state
  // ---------------------------------------------------------------
  fsm_e            state_q, state_d;
  logic [ZW-1:0]   zone_q, zone_d;
  logic [ZW-1:0]   clr_q, clr_d;
  logic            bad_q, bad_d;
  logic            mod_done_q, mod_done_d;
  logic            mod_ok_q, mod_ok_d;
  logic [WpW-1:0]  div_rem_q, div_rem_d;
  logic [WpW-1:0]  div_len_q, div_len_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [CntW-1:0] open_cnt_q, open_cnt_d;
  logic [CntW-1:0] act_cnt_q, act_cnt_d;
  logic [CntW-1:0] area_cnt_q, area_cnt_d;
  logic            out_valid_q, out_valid_d;
  zm_out_t         out_q, out_d;
  zm_in_t          req_q, req_d;
  logic [OffW-1:0] off_q, off_d;

  // zone table
  logic            ram_we, ram_re;
  logic [ZW-1:0]   ram_waddr, ram_raddr;
  zentry_t         ram_wdata, ram_rdata;

  znszm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_ZONES)
  ) u_zone_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------
  // request decode: zone index and in-zone offset
  // ---------------------------------------------------------------
  logic [LogW-1:0] eff_log2;
  logic [LbaW-1:0] req_zid;
  logic [OffW-1:0] req_off;
  logic            accept, out_free;

  assign eff_log2   = (zone_log2_q > LogW'(MaxLog)) ? LogW'(MaxLog) : zone_log2_q;
  assign req_zid    = in_req_i.start_lba >> eff_log2;
  assign req_off    = in_req_i.start_lba[OffW-1:0] & ~({OffW{1'b1}} << eff_log2);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------
  // per-zone command evaluation on the entry just read
  // ---------------------------------------------------------------
  zentry_t         ent, ent_n;
  logic [2:0]      st_code;
  logic [CntW-1:0] open_n, act_n, area_n;
  logic            need_mod;
  logic [WpW:0]    off_p1, wp_area;
  logic [WpW-1:0]  flush_len, gran_eff;
  logic            win_bad, is_act;

  assign ent       = ram_rdata;
  assign off_p1    = {2'b00, off_q} + (WpW+1)'(1);
  assign wp_area   = {1'b0, ent.wp} + {1'b0, area_lbas_q};
  assign flush_len = off_p1[WpW-1:0] - ent.wp;
  assign gran_eff  = (flush_gran_q == '0) ? WpW'(1) : flush_gran_q;
  assign is_act    = (ent.zstate == ZS_IOPEN) || (ent.zstate == ZS_EOPEN) ||
                     (ent.zstate == ZS_CLOSED);
  assign win_bad   = ({1'b0, off_q} < ent.wp) || (off_p1 > wp_area) ||
                     (off_p1 > {1'b0, zone_cap_q});

  always_comb begin
    ent_n    = ent;
    st_code  = SC_OK;
    open_n   = open_cnt_q;
    act_n    = act_cnt_q;
    area_n   = area_cnt_q;
    need_mod = 1'b0;
    case (req_q.func)
      FN_CLOSE: begin
        if (ent.zstate == ZS_IOPEN || ent.zstate == ZS_EOPEN) begin
          ent_n.zstate = ZS_CLOSED;
          open_n       = sat_dec(open_cnt_q);
        end else if (ent.zstate != ZS_CLOSED) begin
          st_code = SC_TRANS;
        end
      end
      FN_FINISH: begin
        if (is_act) begin
          if (ent.zstate != ZS_CLOSED) open_n = sat_dec(open_cnt_q);
          act_n = sat_dec(act_cnt_q);
          if (ent.area_valid) area_n = sat_dec(area_cnt_q);
          ent_n.area_valid = 1'b0;
          ent_n.zstate     = ZS_FULL;
        end else if (ent.zstate == ZS_EMPTY) begin
          ent_n.zstate = ZS_FULL;
        end else if (ent.zstate != ZS_FULL) begin
          st_code = SC_TRANS;
        end
      end
      FN_OPEN: begin
        if (ent.zstate == ZS_EMPTY) begin
          if (act_cnt_q >= max_active_q) begin
            st_code = SC_NOACT;
          end else if (open_cnt_q >= max_open_q) begin
            st_code = SC_NOOPEN;
          end else if (req_q.area_request && (area_cnt_q >= max_area_q)) begin
            st_code = SC_NOAREA;
          end else begin
            if (req_q.area_request) begin
              area_n           = area_cnt_q + CntW'(1);
              ent_n.area_valid = 1'b1;
            end
            act_n        = act_cnt_q + CntW'(1);
            open_n       = open_cnt_q + CntW'(1);
            ent_n.zstate = ZS_EOPEN;
          end
        end else if (ent.zstate == ZS_CLOSED) begin
          if (open_cnt_q >= max_open_q) begin
            st_code = SC_NOOPEN;
          end else begin
            open_n       = open_cnt_q + CntW'(1);
            ent_n.zstate = ZS_EOPEN;
          end
        end else if (ent.zstate == ZS_IOPEN) begin
          ent_n.zstate = ZS_EOPEN;
        end else if (ent.zstate != ZS_EOPEN) begin
          st_code = SC_TRANS;
        end
      end
      FN_RESET: begin
        if (ent.zstate > ZS_FULL) begin
          st_code = SC_TRANS;
        end else begin
          if (ent.zstate == ZS_IOPEN || ent.zstate == ZS_EOPEN) begin
            open_n = sat_dec(open_cnt_q);
          end
          if (is_act) begin
            act_n = sat_dec(act_cnt_q);
            if (ent.area_valid) area_n = sat_dec(area_cnt_q);
          end
          ent_n = '0;
        end
      end
      FN_OFFLINE: begin
        if (ent.zstate == ZS_RONLY) begin
          ent_n.zstate = ZS_OFFLINE;
        end else if (ent.zstate != ZS_OFFLINE) begin
          st_code = SC_TRANS;
        end
      end
      FN_FLUSH: begin
        if (!ent.area_valid || win_bad) begin
          st_code = SC_BADOP;
        end else if (!mod_done_q) begin
          need_mod = 1'b1;
        end else if (!mod_ok_q) begin
          st_code = SC_BADFIELD;
        end else if (!is_act) begin
          st_code = SC_BADOP;
        end else begin
          ent_n.wp = off_p1[WpW-1:0];
          if (off_p1[WpW-1:0] == zone_cap_q) begin
            if (ent.zstate != ZS_CLOSED) open_n = sat_dec(open_cnt_q);
            act_n            = sat_dec(act_cnt_q);
            area_n           = sat_dec(area_cnt_q);
            ent_n.area_valid = 1'b0;
            ent_n.zstate     = ZS_FULL;
          end
        end
      end
      default: st_code = SC_BADOP;
    endcase
  end

  // ---------------------------------------------------------------
  // granule remainder, one bit a cycle
  // ---------------------------------------------------------------
  logic [WpW:0]   div_trial;
  logic [WpW-1:0] div_rem_n;

  assign div_trial = {div_rem_q, div_len_q[WpW-1]};
  assign div_rem_n = (div_trial >= {1'b0, gran_eff}) ?
                     WpW'(div_trial - {1'b0, gran_eff}) : div_trial[WpW-1:0];

  // ---------------------------------------------------------------
  // sequencer: next state, table access and completion load
  // ---------------------------------------------------------------
  logic last_zone;

  assign last_zone = !req_q.all_zones || (zone_q == LastZone);

  always_comb begin
    state_d     = state_q;
    zone_d      = zone_q;
    clr_d       = clr_q;
    bad_d       = bad_q;
    mod_done_d  = mod_done_q;
    mod_ok_d    = mod_ok_q;
    div_rem_d   = div_rem_q;
    div_len_d   = div_len_q;
    div_cnt_d   = div_cnt_q;
    open_cnt_d  = open_cnt_q;
    act_cnt_d   = act_cnt_q;
    area_cnt_d  = area_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    req_d       = req_q;
    off_d       = off_q;
    ram_we      = 1'b0;
    ram_waddr   = zone_q;
    ram_wdata   = ent_n;
    ram_re      = 1'b0;
    ram_raddr   = zone_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ZW'(1);
        if (clr_q == LastZone) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          req_d      = in_req_i;
          mod_done_d = 1'b0;
          if (in_req_i.all_zones) begin
            zone_d  = '0;
            off_d   = '0;
            bad_d   = 1'b0;
            state_d = S_RD;
          end else begin
            zone_d = req_zid[ZW-1:0];
            off_d  = req_off;
            bad_d  = (req_zid >= NumZonesLba);
            state_d = (req_zid >= NumZonesLba) ? S_EX : S_RD;
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EX;
      end
      S_EX: begin
        if (bad_q) begin
          if (out_free) begin
            out_valid_d        = 1'b1;
            out_d.status       = SC_BADFIELD;
            out_d.zone_st      = '0;
            out_d.write_pointer = '0;
            out_d.open_count   = open_cnt_q;
            out_d.active_count = act_cnt_q;
            out_d.area_count   = area_cnt_q;
            state_d            = S_IDLE;
          end
        end else if (need_mod) begin
          div_rem_d = '0;
          div_len_d = flush_len;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end else if (!last_zone || out_free) begin
          ram_we     = 1'b1;
          open_cnt_d = open_n;
          act_cnt_d  = act_n;
          area_cnt_d = area_n;
          mod_done_d = 1'b0;
          if (last_zone) begin
            out_valid_d         = 1'b1;
            out_d.status        = req_q.all_zones ? SC_OK : st_code;
            out_d.zone_st       = ent_n.zstate;
            out_d.write_pointer = ent_n.wp;
            out_d.open_count    = open_n;
            out_d.active_count  = act_n;
            out_d.area_count    = area_n;
            state_d             = S_IDLE;
          end else begin
            zone_d  = zone_q + ZW'(1);
            state_d = S_RD;
          end
        end
      end
      S_DIV: begin
        div_rem_d = div_rem_n;
        div_len_d = {div_len_q[WpW-2:0], 1'b0};
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          mod_done_d = 1'b1;
          mod_ok_d   = (div_rem_n == '0);
          state_d    = S_EX;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      zone_q      <= '0;
      clr_q       <= '0;
      bad_q       <= 1'b0;
      mod_done_q  <= 1'b0;
      mod_ok_q    <= 1'b0;
      div_cnt_q   <= '0;
      open_cnt_q  <= '0;
      act_cnt_q   <= '0;
      area_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zone_q      <= zone_d;
      clr_q       <= clr_d;
      bad_q       <= bad_d;
      mod_done_q  <= mod_done_d;
      mod_ok_q    <= mod_ok_d;
      div_cnt_q   <= div_cnt_d;
      open_cnt_q  <= open_cnt_d;
      act_cnt_q   <= act_cnt_d;
      area_cnt_q  <= area_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    off_q     <= off_d;
    out_q     <= out_d;
    div_rem_q <= div_rem_d;
    div_len_q <= div_len_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // an open zone is always also an active one
  a_open_le_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt_q <= act_cnt_q)
    else $error("open count exceeds active count");

  // an area is only held by an active zone
  a_area_le_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    area_cnt_q <= act_cnt_q)
    else $error("area count exceeds active count");

  // the remainder unit only runs for a flush
  a_div_flush_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> req_q.func == FN_FLUSH)
    else $error("remainder unit started for a non-flush command");

  // a table read is always consumed in the next cycle
  a_rd_then_ex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |=> state_q == S_EX)
    else $error("table read not followed by evaluation");

  // a completion is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && state_q == S_EX && last_zone |=> $stable(out_q))
    else $error("pending completion overwritten");

endmodule

FILE: tb/sv/tb_zoned_namespace_zone_manager_unit.sv
// tb_zoned_namespace_zone_manager_unit: self-checking bench for the zone manager
// drives zone commands and apb limits, predicts each completion in-bench
// depends on znszm_pkg and zoned_namespace_zone_manager_unit
`timescale 1ns / 100ps

module tb_zoned_namespace_zone_manager_unit;
  import znszm_pkg::*;

  localparam int unsigned NumZones    = 1024;
  localparam int unsigned RegCount    = 7;
  localparam int unsigned NumSettings = 7;
  localparam int unsigned NumSegs     = 6;
  localparam int unsigned SegItems    = 134;
  localparam int unsigned HoldSeg     = 4;
  localparam int unsigned PauseSeg    = 5;
  localparam int unsigned KeepSeg     = 3;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned PrintCap    = 50;
  localparam int unsigned NumDir      = 25;
  // operation codes the block does not know
  localparam logic [FuncW-1:0] FnBad6 = 3'd6;
  localparam logic [FuncW-1:0] FnBad7 = 3'd7;

  // one directed row: setting to load first (-1 keeps it), request, typed result
  typedef struct {
    int      setting;
    zm_in_t  cmd;
    bit      typed;
    zm_out_t result;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  zm_in_t      in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  zm_out_t     out_req_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted zone table and counters
  zstate_e         zst_q   [NumZones];
  logic [WpW-1:0]  zwp_q   [NumZones];
  bit              zarea_q [NumZones];
  logic [CntW-1:0] open_n, active_n, area_n;

  // predicted register values, reset defaults
  logic [CntW-1:0] lim_active    = 11'd1024;
  logic [CntW-1:0] lim_open      = 11'd1024;
  logic [CntW-1:0] lim_area      = 11'd0;
  logic [LogW-1:0] cfg_log2      = 5'd16;
  logic [WpW-1:0]  cfg_cap       = 21'd65536;
  logic [WpW-1:0]  cfg_area_lbas = 21'd256;
  logic [WpW-1:0]  cfg_gran      = 21'd16;

  // limit settings in register order: active, open, area, log2, capacity, area lbas, granule
  int unsigned setting_tbl [NumSettings][RegCount] = '{
    '{2, 1, 1, 4, 16, 8, 4},
    '{4, 3, 2, 4, 16, 8, 4},
    '{1024, 1024, 1024, 20, 1048576, 1048576, 1048576},
    '{1, 1, 0, 0, 1, 1, 1},
    '{8, 4, 8, 3, 6, 4, 2},
    '{3, 3, 3, 10, 1000, 512, 100},
    '{1024, 1024, 16, 16, 65536, 256, 16}
  };

  zm_out_t     completions_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 7;
  int unsigned dst_idle_pct = 58;
  bit          hold_req = 1'b0;
  dir_row_t    dir_tbl [NumDir];

  zoned_namespace_zone_manager_unit #(
    .NUM_ZONES(NumZones)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic zm_in_t mk_cmd(input logic [FuncW-1:0] fn, input logic [LbaW-1:0] lba,
                                    input bit want_area, input bit every_zone);
    zm_in_t c;
    c.func         = fn;
    c.start_lba    = lba;
    c.area_request = want_area;
    c.all_zones    = every_zone;
    return c;
  endfunction

  function automatic zm_out_t mk_done(input status_e st, input zstate_e zs, input int unsigned wp,
                                      input int unsigned opn, input int unsigned act,
                                      input int unsigned ara);
    zm_out_t r;
    r.status        = st;
    r.zone_st       = zs;
    r.write_pointer = WpW'(wp);
    r.open_count    = CntW'(opn);
    r.active_count  = CntW'(act);
    r.area_count    = CntW'(ara);
    return r;
  endfunction

  function automatic logic [CntW-1:0] cnt_release(input logic [CntW-1:0] c);
    return (c != '0) ? c - 1'b1 : c;
  endfunction

  function automatic int unsigned zone_shift();
    return (cfg_log2 > MaxLog) ? MaxLog : int'(cfg_log2);
  endfunction

  // one zone step of a command; updates the predicted table and counters
  function automatic status_e zone_command(input logic [FuncW-1:0] fn, input int unsigned z,
                                           input longint lba, input bit want_area);
    zstate_e s;
    longint  wp, off, end_a, end_c, last, gran;
    s = zst_q[z];
    case (fn)
      FN_CLOSE: begin
        if (s == ZS_IOPEN || s == ZS_EOPEN) begin
          zst_q[z] = ZS_CLOSED;
          open_n = cnt_release(open_n);
          return SC_OK;
        end
        return (s == ZS_CLOSED) ? SC_OK : SC_TRANS;
      end
      FN_FINISH: begin
        if (s == ZS_IOPEN || s == ZS_EOPEN || s == ZS_CLOSED) begin
          if (s != ZS_CLOSED) open_n = cnt_release(open_n);
          active_n = cnt_release(active_n);
          if (zarea_q[z]) area_n = cnt_release(area_n);
          zarea_q[z] = 1'b0;
          zst_q[z] = ZS_FULL;
          return SC_OK;
        end
        if (s == ZS_EMPTY) begin
          zst_q[z] = ZS_FULL;
          return SC_OK;
        end
        return (s == ZS_FULL) ? SC_OK : SC_TRANS;
      end
      FN_OPEN: begin
        if (s == ZS_EMPTY) begin
          if (active_n >= lim_active) return SC_NOACT;
          if (open_n >= lim_open) return SC_NOOPEN;
          if (want_area) begin
            if (area_n >= lim_area) return SC_NOAREA;
            area_n = area_n + 1'b1;
            zarea_q[z] = 1'b1;
          end
          active_n = active_n + 1'b1;
          open_n = open_n + 1'b1;
          zst_q[z] = ZS_EOPEN;
          return SC_OK;
        end
        if (s == ZS_CLOSED) begin
          if (open_n >= lim_open) return SC_NOOPEN;
          open_n = open_n + 1'b1;
          zst_q[z] = ZS_EOPEN;
          return SC_OK;
        end
        if (s == ZS_IOPEN) begin
          zst_q[z] = ZS_EOPEN;
          return SC_OK;
        end
        return (s == ZS_EOPEN) ? SC_OK : SC_TRANS;
      end
      FN_RESET: begin
        if (s > ZS_FULL) return SC_TRANS;
        if (s == ZS_IOPEN || s == ZS_EOPEN) open_n = cnt_release(open_n);
        if (s == ZS_IOPEN || s == ZS_EOPEN || s == ZS_CLOSED) begin
          active_n = cnt_release(active_n);
          if (zarea_q[z]) area_n = cnt_release(area_n);
        end
        zst_q[z] = ZS_EMPTY;
        zwp_q[z] = '0;
        zarea_q[z] = 1'b0;
        return SC_OK;
      end
      FN_OFFLINE: begin
        if (s == ZS_RONLY) begin
          zst_q[z] = ZS_OFFLINE;
          return SC_OK;
        end
        return (s == ZS_OFFLINE) ? SC_OK : SC_TRANS;
      end
      FN_FLUSH: begin
        // window runs from the write pointer to the end of the area, capped at capacity
        wp    = longint'(zwp_q[z]);
        off   = lba & ((longint'(1) << zone_shift()) - 1);
        end_a = wp + longint'(cfg_area_lbas) - 1;
        end_c = longint'(cfg_cap) - 1;
        last  = (end_a < end_c) ? end_a : end_c;
        gran  = (cfg_gran != '0) ? longint'(cfg_gran) : 1;
        if (!zarea_q[z] || off < wp || off > last) return SC_BADOP;
        if ((off - wp + 1) % gran != 0) return SC_BADFIELD;
        if (s != ZS_IOPEN && s != ZS_EOPEN && s != ZS_CLOSED) return SC_BADOP;
        zwp_q[z] = WpW'(off + 1);
        // flushed up to capacity: zone goes full and gives back its area
        if (off + 1 == longint'(cfg_cap)) begin
          if (s != ZS_CLOSED) open_n = cnt_release(open_n);
          active_n = cnt_release(active_n);
          area_n = cnt_release(area_n);
          zarea_q[z] = 1'b0;
          zst_q[z] = ZS_FULL;
        end
        return SC_OK;
      end
      default: return SC_BADOP;
    endcase
  endfunction

  // completion of one accepted command
  function automatic zm_out_t expected_completion(input zm_in_t cmd);
    zm_out_t     r;
    int unsigned lg;
    longint      zid;
    lg = zone_shift();
    r = '0;
    if (cmd.all_zones) begin
      // walk every zone by its first block; per-zone status is dropped
      for (int unsigned z = 0; z < NumZones; z++)
        void'(zone_command(cmd.func, z, longint'(z) << lg, cmd.area_request));
      r.status        = SC_OK;
      r.zone_st       = zst_q[NumZones-1];
      r.write_pointer = zwp_q[NumZones-1];
    end else begin
      zid = longint'(cmd.start_lba) >> lg;
      if (zid >= longint'(NumZones)) begin
        r.status = SC_BADFIELD;
      end else begin
        r.status = zone_command(cmd.func, int'(zid), longint'(cmd.start_lba), cmd.area_request);
        r.zone_st       = zst_q[zid];
        r.write_pointer = zwp_q[zid];
      end
    end
    r.open_count   = open_n;
    r.active_count = active_n;
    r.area_count   = area_n;
    return r;
  endfunction

  // random command, mostly well-formed flows on a few hot zones
  function automatic zm_in_t next_command();
    zm_in_t      c;
    int unsigned roll, z, lg;
    longint      span, off;
    lg   = zone_shift();
    span = longint'(1) << lg;
    c = mk_cmd(FN_OPEN, $urandom(), 1'($urandom_range(1, 0)), 1'b0);
    roll = $urandom_range(99, 0);
    if (roll == 0) begin
      c.all_zones = 1'b1;
      c.func = 3'($urandom_range(7, 0));
      return c;
    end
    // noise: any operation on any block
    if (roll < 9) begin
      c.func = 3'($urandom_range(7, 0));
      return c;
    end
    z = ($urandom_range(3, 0) != 0) ? $urandom_range(7, 0) : $urandom_range(NumZones-1, 0);
    off = longint'($urandom()) % span;
    roll = $urandom_range(99, 0);
    if (roll < 35) begin
      c.func = FN_FLUSH;
      if (roll < 12)
        off = longint'(cfg_cap) - 1;
      else if (roll < 30)
        off = longint'(zwp_q[z]) - 1 + longint'(cfg_gran) *
              longint'($urandom_range(1 + int'(cfg_area_lbas / cfg_gran), 1));
    end else if (roll < 60) begin
      c.func = FN_OPEN;
      c.area_request = ($urandom_range(9, 0) < 7);
    end else if (roll < 70) begin
      c.func = FN_CLOSE;
    end else if (roll < 78) begin
      c.func = FN_FINISH;
    end else if (roll < 92) begin
      c.func = FN_RESET;
    end else begin
      c.func = FN_OFFLINE;
    end
    c.start_lba = 32'((longint'(z) << lg) + (off % span));
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintCap)
      $display("[%0t] completion mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_completion(input zm_out_t got);
    zm_out_t want;
    if (completions_due.size() == 0) begin
      flag_mismatch("completion with none due", 1, 0);
      return;
    end
    want = completions_due.pop_front();
    if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
    if (got.zone_st !== want.zone_st)
      flag_mismatch("zone_st", got.zone_st, want.zone_st);
    if (got.write_pointer !== want.write_pointer)
      flag_mismatch("write_pointer", got.write_pointer, want.write_pointer);
    if (got.open_count !== want.open_count)
      flag_mismatch("open_count", got.open_count, want.open_count);
    if (got.active_count !== want.active_count)
      flag_mismatch("active_count", got.active_count, want.active_count);
    if (got.area_count !== want.area_count)
      flag_mismatch("area_count", got.area_count, want.area_count);
  endtask

  // offer one request, wait for accept, queue its completion; returns on a falling edge
  task automatic issue_command(input zm_in_t cmd, input bit typed, input zm_out_t typed_res);
    zm_out_t predicted;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= cmd;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = expected_completion(cmd);
    completions_due.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every completion due
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (completions_due.size() != 0);
  endtask

  // apb writes of one setting, block idle
  task automatic load_setting(input int unsigned k);
    logic [31:0] v;
    for (int unsigned r = 0; r < RegCount; r++) begin
      v = setting_tbl[k][r];
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(4 * r);
      pwdata  <= v;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      case (cfg_reg_e'(r))
        REG_MAX_ACTIVE: lim_active    = v[CntW-1:0];
        REG_MAX_OPEN:   lim_open      = v[CntW-1:0];
        REG_MAX_AREA:   lim_area      = v[CntW-1:0];
        REG_ZONE_LOG2:  cfg_log2      = v[LogW-1:0];
        REG_ZONE_CAP:   cfg_cap       = v[WpW-1:0];
        REG_AREA_LBAS:  cfg_area_lbas = v[WpW-1:0];
        REG_FLUSH_GRAN: cfg_gran      = v[WpW-1:0];
        default: ;
      endcase
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // completion side: check on accept, stall at random or for a long hold
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) check_completion(out_req_o);
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < dst_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_zoned_namespace_zone_manager_unit: done, errors");
    $finish;
  end

  // stimulus
  initial begin
    for (int unsigned z = 0; z < NumZones; z++) begin
      zst_q[z] = ZS_EMPTY;
      zwp_q[z] = '0;
      zarea_q[z] = 1'b0;
    end
    open_n = '0;
    active_n = '0;
    area_n = '0;

    // directed: reset limits with typed results, then a tight setting
    dir_tbl = '{
      '{-1, mk_cmd(FN_OPEN, 32'h0000_0000, 0, 0), 1, mk_done(SC_OK, ZS_EOPEN, 0, 1, 1, 0)},
      '{-1, mk_cmd(FN_OPEN, 32'h0001_0000, 1, 0), 1, mk_done(SC_NOAREA, ZS_EMPTY, 0, 1, 1, 0)},
      '{-1, mk_cmd(FN_CLOSE, 32'hFFFF_FFFF, 1, 0), 1,
        mk_done(SC_BADFIELD, ZS_EMPTY, 0, 1, 1, 0)},
      '{-1, mk_cmd(FnBad6, 32'h0000_0000, 0, 0), 1, mk_done(SC_BADOP, ZS_EOPEN, 0, 1, 1, 0)},
      '{-1, mk_cmd(FnBad7, 32'h0002_0000, 0, 0), 1, mk_done(SC_BADOP, ZS_EMPTY, 0, 1, 1, 0)},
      '{-1, mk_cmd(FN_CLOSE, 32'h0000_0000, 0, 0), 1, mk_done(SC_OK, ZS_CLOSED, 0, 0, 1, 0)},
      '{-1, mk_cmd(FN_OFFLINE, 32'h0000_0000, 0, 0), 1,
        mk_done(SC_TRANS, ZS_CLOSED, 0, 0, 1, 0)},
      '{-1, mk_cmd(FN_FINISH, 32'h0000_0000, 0, 0), 1, mk_done(SC_OK, ZS_FULL, 0, 0, 0, 0)},
      '{-1, mk_cmd(FN_RESET, 32'h0000_FFFF, 0, 0), 1, mk_done(SC_OK, ZS_EMPTY, 0, 0, 0, 0)},
      '{-1, mk_cmd(FN_FINISH, 32'h0003_0000, 0, 0), 1, mk_done(SC_OK, ZS_FULL, 0, 0, 0, 0)},
      '{-1, mk_cmd(FN_OPEN, 32'h0003_0000, 0, 0), 1, mk_done(SC_TRANS, ZS_FULL, 0, 0, 0, 0)},
      '{-1, mk_cmd(FN_FLUSH, 32'h0003_000F, 0, 0), 1, mk_done(SC_BADOP, ZS_FULL, 0, 0, 0, 0)},
      '{-1, mk_cmd(FN_RESET, 32'h0000_0000, 0, 1), 1, mk_done(SC_OK, ZS_EMPTY, 0, 0, 0, 0)},
      '{0, mk_cmd(FN_OPEN, 32'd0, 1, 0), 0, '0},
      '{-1, mk_cmd(FN_OPEN, 32'd16, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_CLOSE, 32'd0, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_OPEN, 32'd16, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_OPEN, 32'd32, 1, 0), 0, '0},
      '{-1, mk_cmd(FN_FLUSH, 32'd3, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_FLUSH, 32'd5, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_FLUSH, 32'd15, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_FLUSH, 32'd11, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_FLUSH, 32'd15, 0, 0), 0, '0},
      '{-1, mk_cmd(FN_OPEN, 32'd0, 1, 1), 0, '0},
      '{-1, mk_cmd(FN_FINISH, 32'd0, 0, 1), 0, '0}
    };

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].setting >= 0) begin
        drain();
        load_setting(dir_tbl[i].setting);
      end
      issue_command(dir_tbl[i].cmd, dir_tbl[i].typed, dir_tbl[i].result);
    end

    // random segments, one setting each; idling moves from sender-light to receiver-light to none
    for (int unsigned seg = 0; seg < NumSegs; seg++) begin
      drain();
      load_setting(seg + 1);
      src_idle_pct = (seg < 2) ? 7 : (seg < 4) ? 58 : 0;
      dst_idle_pct = (seg < 2) ? 58 : (seg < 4) ? 7 : 0;
      if (seg == HoldSeg) hold_req = 1'b1;
      if (seg != KeepSeg) issue_command(mk_cmd(FN_RESET, '0, 1'b0, 1'b1), 1'b0, '0);
      for (int unsigned n = 0; n < SegItems; n++) begin
        if (seg == PauseSeg && n == SegItems / 2) drain();
        issue_command(next_command(), 1'b0, '0);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_zoned_namespace_zone_manager_unit: done, clean");
    end else begin
      $display("tb_zoned_namespace_zone_manager_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: zoned_namespace_zone_manager_unit.f
rtl/znszm_pkg.sv
rtl/znszm_ram.sv
rtl/zoned_namespace_zone_manager_unit.sv
tb/sv/tb_zoned_namespace_zone_manager_unit.sv
